// File: rtl/rcs_pkg.sv
`default_nettype none

package rcs_pkg;

    // Number of variables that can be ranked in one job.
    localparam int NUM_VARS = 128;
    // Width of the chosen-variable map, fixed by the 7-bit variable number.
    localparam int MAP_BITS = 128;

    localparam int VAR_W    = 7;
    localparam int ROUND_W  = 12;
    localparam int DEGREE_W = 16;
    localparam int MODE_W   = 2;
    localparam int NB_W     = 2;
    localparam int CNT_W    = 8;

    // Both stream payloads pack three fields and pad to whole bytes.
    localparam int FIELDS_W = VAR_W + ROUND_W + DEGREE_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Entry kinds carried on tuser.
    localparam logic FUNC_CANDIDATE = 1'b0;
    localparam logic FUNC_CHOSEN    = 1'b1;

    // Ranking modes.
    localparam logic [MODE_W-1:0] MODE_ROUND_FIRST     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEGREE_FIRST    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROUND_FIRST_NB  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEGREE_FIRST_NB = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET           = MODE_DEGREE_FIRST_NB;

endpackage

`default_nettype wire

// File: rtl/ranked_candidate_selector.sv
`default_nettype none

// Ranked candidate selector.
// Input stream (s_*): each transfer is one entry of a job. tuser = 1 marks a
// variable that is already chosen and only sets its bit in the 128-bit map;
// tuser = 0 marks a candidate with its round and rough degree, ranked against
// the running best under the mode held in the configuration register.
// tlast on a candidate ends the job; tlast on a chosen entry is ignored.
// Output stream (m_*): one transfer per job with the winner's position in
// the candidate sequence, its round and its degree.
// The last candidate's transfer enters the input register; the job's result
// is then loaded into the result register and taken from there (one input
// register, one result register). Throughput: one entry per cycle unless a
// job end is held (see below); the ranking compare and state update sit
// between the input register and the result register.
// When the receiver stalls, the result waits in the output register and
// entries keep flowing until a second job ends; that end entry then holds
// in the input register and s_tready drops until the result is taken. Reset
// clears the job state and the map, selects mode 3, empties both registers.
// The user must write the mode via cfg_wr_en only between jobs; not enforced.
module ranked_candidate_selector
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration: ranking mode.
    input  wire logic                         cfg_wr_en,
    input  wire logic [rcs_pkg::MODE_W-1:0]   cfg_wr_data,
    // Entry stream.
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    // var_index[6:0], round_value[18:7], rough_degree[34:19], zero pad
    input  wire logic [rcs_pkg::TDATA_W-1:0]  s_tdata,
    // func
    input  wire logic                         s_tuser,
    input  wire logic                         s_tlast,
    // Result stream.
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    // best_position[6:0], best_round[18:7], best_degree[34:19], zero pad
    output      logic [rcs_pkg::TDATA_W-1:0]  m_tdata
);
    import rcs_pkg::*;

    // Configuration register.
    logic [MODE_W-1:0]   mode_reg;

    // Input register.
    logic                stg_valid_reg;
    logic                stg_func_reg;
    logic [VAR_W-1:0]    stg_var_reg;
    logic [ROUND_W-1:0]  stg_round_reg;
    logic [DEGREE_W-1:0] stg_degree_reg;
    logic                stg_last_reg;

    // Job state.
    logic [MAP_BITS-1:0] map_reg,      map_next;
    logic [ROUND_W-1:0]  lead_round_reg,  lead_round_next;
    logic [DEGREE_W-1:0] lead_degree_reg, lead_degree_next;
    logic [NB_W-1:0]     lead_nb_reg,     lead_nb_next;
    logic [VAR_W-1:0]    lead_pos_reg,    lead_pos_next;
    logic [CNT_W-1:0]    cand_cnt_reg,    cand_cnt_next;
    logic                have_lead_reg,   have_lead_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [VAR_W-1:0]    out_pos_reg;
    logic [ROUND_W-1:0]  out_round_reg;
    logic [DEGREE_W-1:0] out_degree_reg;

    logic                stg_is_end;
    logic                stg_advance;
    logic                take_in;
    logic                emit;
    logic [VAR_W-1:0]    var_up;
    logic [VAR_W-1:0]    var_dn;
    logic                nb_up;
    logic                nb_dn;
    logic [NB_W-1:0]     nb_cnt;
    logic                same_rd;
    logic                nb_win;
    logic                round_win;
    logic                degree_win;
    logic                beats;
    logic                rank_ok;
    logic                chosen_ok;
    logic [VAR_W-1:0]    emit_pos;

    // Handshake: the input register moves on unless it holds a job end
    // while the result register is full and m_tready is low.
    assign stg_is_end  = stg_valid_reg && (stg_func_reg == FUNC_CANDIDATE) && stg_last_reg;
    assign stg_advance = stg_valid_reg && (!stg_is_end || !out_valid_reg || m_tready);
    assign s_tready    = !stg_valid_reg || stg_advance;
    assign take_in     = s_tvalid && s_tready;
    assign emit        = stg_advance && stg_is_end;

    // Chosen neighbours of the candidate: v-1 and v+1, none past the ends.
    assign var_up = stg_var_reg + VAR_W'(1);
    assign var_dn = stg_var_reg - VAR_W'(1);
    assign nb_up  = (stg_var_reg != {VAR_W{1'b1}}) ? map_reg[var_up] : 1'b0;
    assign nb_dn  = (stg_var_reg != '0) ? map_reg[var_dn] : 1'b0;
    assign nb_cnt = NB_W'(nb_up) + NB_W'(nb_dn);

    // Ranking against the running best.
    assign round_win  = (stg_round_reg > lead_round_reg) ||
                        ((stg_round_reg == lead_round_reg) &&
                         (stg_degree_reg < lead_degree_reg));
    assign degree_win = (stg_degree_reg < lead_degree_reg) ||
                        ((stg_degree_reg == lead_degree_reg) &&
                         (stg_round_reg > lead_round_reg));
    assign same_rd    = (stg_round_reg == lead_round_reg) &&
                        (stg_degree_reg == lead_degree_reg);
    assign nb_win     = same_rd && (nb_cnt < lead_nb_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_ROUND_FIRST:     beats = round_win;
            MODE_DEGREE_FIRST:    beats = degree_win;
            MODE_ROUND_FIRST_NB:  beats = round_win || nb_win;
            MODE_DEGREE_FIRST_NB: beats = degree_win || nb_win;
            default:              beats = degree_win || nb_win;
        endcase
    end

    assign rank_ok   = {1'b0, cand_cnt_reg} < (CNT_W + 1)'(NUM_VARS);
    assign chosen_ok = {2'b00, stg_var_reg} < (VAR_W + 2)'(NUM_VARS);

    // Job state update for the entry in the input register.
    always_comb
    begin
        map_next         = map_reg;
        lead_round_next  = lead_round_reg;
        lead_degree_next = lead_degree_reg;
        lead_nb_next     = lead_nb_reg;
        lead_pos_next    = lead_pos_reg;
        cand_cnt_next    = cand_cnt_reg;
        have_lead_next   = have_lead_reg;
        if (stg_advance)
        begin
            if (stg_func_reg == FUNC_CHOSEN)
            begin
                if (chosen_ok)
                begin
                    map_next[stg_var_reg] = 1'b1;
                end
            end
            else
            begin
                if (rank_ok && (!have_lead_reg || beats))
                begin
                    have_lead_next   = 1'b1;
                    lead_round_next  = stg_round_reg;
                    lead_degree_next = stg_degree_reg;
                    lead_nb_next     = nb_cnt;
                    lead_pos_next    = cand_cnt_reg[VAR_W-1:0];
                end
                if (cand_cnt_reg != CNT_MAX)
                begin
                    cand_cnt_next = cand_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Winner position; MODE_DEGREE_FIRST alone reports position 0 for round 0.
    assign emit_pos = ((mode_reg == MODE_DEGREE_FIRST) && (lead_round_next == '0)) ?
                      '0 : lead_pos_next;

    // Result register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RESET;
            stg_valid_reg   <= 1'b0;
            map_reg         <= '0;
            lead_round_reg  <= '0;
            lead_degree_reg <= '1;
            lead_nb_reg     <= '0;
            lead_pos_reg    <= '0;
            cand_cnt_reg    <= '0;
            have_lead_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (take_in)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (stg_advance)
            begin
                stg_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            // A job end returns all job state to its reset values.
            if (emit)
            begin
                map_reg         <= '0;
                lead_round_reg  <= '0;
                lead_degree_reg <= '1;
                lead_nb_reg     <= '0;
                lead_pos_reg    <= '0;
                cand_cnt_reg    <= '0;
                have_lead_reg   <= 1'b0;
            end
            else
            begin
                map_reg         <= map_next;
                lead_round_reg  <= lead_round_next;
                lead_degree_reg <= lead_degree_next;
                lead_nb_reg     <= lead_nb_next;
                lead_pos_reg    <= lead_pos_next;
                cand_cnt_reg    <= cand_cnt_next;
                have_lead_reg   <= have_lead_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stg_func_reg   <= s_tuser;
            stg_var_reg    <= s_tdata[VAR_W-1:0];
            stg_round_reg  <= s_tdata[VAR_W +: ROUND_W];
            stg_degree_reg <= s_tdata[VAR_W + ROUND_W +: DEGREE_W];
            stg_last_reg   <= s_tlast;
        end
        if (emit)
        begin
            out_pos_reg    <= emit_pos;
            out_round_reg  <= lead_round_next;
            out_degree_reg <= lead_degree_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_degree_reg, out_round_reg, out_pos_reg};

endmodule

`default_nettype wire

// File: rtl/rcs_checker.sv
`default_nettype none

module rcs_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         s_tuser,
    input wire logic                         s_tlast,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [rcs_pkg::TDATA_W-1:0]  m_tdata
);
    import rcs_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A new result follows the job's last candidate via the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && s_tlast && (s_tuser == FUNC_CANDIDATE), 2))
        else $error("result without a preceding job end");

    // Input backpressure only comes from a stalled result.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked without output stall");

    // The pad bits of the result stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[TDATA_W-1:FIELDS_W] == '0))
        else $error("result pad bits set");

endmodule

bind ranked_candidate_selector rcs_checker u_rcs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
